/* rtl/core/bts_pkg.sv */
// bilinear texture sampler package: field widths, command and register codes,
// blend helper functions. no dependencies.
`default_nettype none

package bts_pkg;

    // payload field widths
    localparam int CMD_W     = 1;
    localparam int INDEX_W   = 16;
    localparam int CHAN_W    = 8;
    localparam int TEXEL_W   = 3 * CHAN_W;
    localparam int COORD_W   = 16;
    localparam int RESULT_W  = 16;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int SIZE_W    = 9;
    localparam int SIZE_RST  = 256;

    // row * width + column of a clamped position fits in twice the size width
    localparam int LIN_W     = 2 * SIZE_W;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_reg;

    // one channel (0 red, 1 green, 2 blue) of a packed texel
    function automatic logic [CHAN_W-1:0] chan(logic [TEXEL_W-1:0] texel, logic [1:0] ch);
        logic [CHAN_W-1:0] c;
        case (ch)
            2'd0:    c = texel[3*CHAN_W-1:2*CHAN_W];
            2'd1:    c = texel[2*CHAN_W-1:CHAN_W];
            default: c = texel[CHAN_W-1:0];
        endcase
        return c;
    endfunction

    // a*(1-t) + b*t with 1 = 65536, exact; the maximum 255 * 65536 fits 24 bits
    function automatic logic [23:0] lerp_h(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                           logic [COORD_W-1:0] t);
        logic [COORD_W:0] wa;
        logic [24:0]      s;
        wa = 17'h10000 - {1'b0, t};
        s  = 25'(a) * 25'(wa) + 25'(b) * 25'(t);
        return s[23:0];
    endfunction

    // second blend across rows, then the Q8.8 part of the 40-bit sum
    function automatic logic [RESULT_W-1:0] lerp_v(logic [23:0] a, logic [23:0] b,
                                                   logic [COORD_W-1:0] t);
        logic [COORD_W:0] wa;
        logic [40:0]      s;
        wa = 17'h10000 - {1'b0, t};
        s  = 41'(a) * 41'(wa) + 41'(b) * 41'(t);
        return s[39:24];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bts_if.sv */
// channel interfaces of the bilinear texture sampler: item input, result output
// and configuration writes. depends on bts_pkg.
`default_nettype none

interface bts_item_if;
    logic                            valid;
    logic                            ready;
    logic [bts_pkg::CMD_W-1:0]       cmd;
    logic [bts_pkg::INDEX_W-1:0]     texel_index;
    logic [bts_pkg::CHAN_W-1:0]      texel_red;
    logic [bts_pkg::CHAN_W-1:0]      texel_green;
    logic [bts_pkg::CHAN_W-1:0]      texel_blue;
    logic [bts_pkg::COORD_W-1:0]     u_coord;
    logic [bts_pkg::COORD_W-1:0]     v_coord;

    modport source (output valid, cmd, texel_index, texel_red, texel_green, texel_blue,
                    u_coord, v_coord, input ready);
    modport sink   (input valid, cmd, texel_index, texel_red, texel_green, texel_blue,
                    u_coord, v_coord, output ready);
endinterface

interface bts_result_if;
    logic                            valid;
    logic                            ready;
    logic [bts_pkg::RESULT_W-1:0]    sample_red;
    logic [bts_pkg::RESULT_W-1:0]    sample_green;
    logic [bts_pkg::RESULT_W-1:0]    sample_blue;

    modport source (output valid, sample_red, sample_green, sample_blue, input ready);
    modport sink   (input valid, sample_red, sample_green, sample_blue, output ready);
endinterface

interface bts_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bts_pkg::CFG_IDX_W-1:0]   index;
    logic [bts_pkg::SIZE_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/bilinear_texture_sampler.sv */
// bilinear texture sampler top level: texel memory, fetch sequencer and blend pipeline.
// depends on bts_pkg and the channel interfaces in bts_if.
//
//   channel  | modport | transfer moves
//   i_smp    | sink    | texel write (cmd 0) or sample request (cmd 1)
//   o_res    | source  | one blended Q8.8 rgb sample per sample request
//   i_cfg    | sink    | image width (index 0) or height (index 1), always ready
//
// the single port of the texel memory sets the rate: a write uses it once, a sample
// four times (one read per neighbour), and the next item waits for the last of them.
// synchronous active-low reset clears control state and sets width and height to 256,
// or to the maximum if smaller; the texel memory is not cleared. a stalled result
// holds the blend stages, and the fetch sequencer waits only when a gathered sample is
// pending and the horizontal blend register ahead of it cannot take it.
`default_nettype none

module bilinear_texture_sampler #(
    parameter int MAX_WIDTH  = bts_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bts_pkg::MAX_HEIGHT_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bts_item_if.sink    i_smp,
    bts_result_if.source o_res,
    bts_cfg_if.sink     i_cfg
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int W_RST = (bts_pkg::SIZE_RST > MAX_WIDTH)  ? MAX_WIDTH  : bts_pkg::SIZE_RST;
    localparam int H_RST = (bts_pkg::SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : bts_pkg::SIZE_RST;
    localparam int SW    = bts_pkg::SIZE_W;
    localparam int CW    = bts_pkg::COORD_W;
    localparam int TW    = bts_pkg::TEXEL_W;

    // ---------------- configuration ----------------
    logic [SW-1:0] r_img_w, r_img_h;
    logic [SW-1:0] n_size;

    always_comb begin
        if (i_cfg.data == '0) begin
            n_size = SW'(1);
        end else if ((i_cfg.index == bts_pkg::CFG_WIDTH) && (int'(i_cfg.data) > MAX_WIDTH)) begin
            n_size = SW'(MAX_WIDTH);
        end else if ((i_cfg.index == bts_pkg::CFG_HEIGHT) &&
                     (int'(i_cfg.data) > MAX_HEIGHT)) begin
            n_size = SW'(MAX_HEIGHT);
        end else begin
            n_size = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= SW'(W_RST);
            r_img_h <= SW'(H_RST);
        end else if (i_cfg.valid) begin
            case (bts_pkg::t_cfg_reg'(i_cfg.index))
                bts_pkg::CFG_WIDTH:  r_img_w <= n_size;
                bts_pkg::CFG_HEIGHT: r_img_h <= n_size;
                default:             ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // ---------------- handshake chain ----------------
    logic r_v1, r_v2, r_pv, r_hv, r_ov;
    logic s5_go, h_free, s4_take, seq_stall, s2_go, s2_done, s2_free, s12, s1_free, acc;
    logic is_write;
    logic [1:0] r_cnt;

    bts_pkg::t_cmd r1_cmd, r2_cmd;

    assign s5_go     = r_hv && (!r_ov || o_res.ready);
    assign h_free    = !r_hv || s5_go;
    assign s4_take   = r_pv && h_free;
    assign seq_stall = r_pv && !h_free;
    assign is_write  = (r2_cmd == bts_pkg::CMD_WRITE);
    assign s2_go     = r_v2 && !seq_stall;
    assign s2_done   = s2_go && (is_write || (r_cnt == 2'd3));
    assign s2_free   = !r_v2 || s2_done;
    assign s12       = r_v1 && s2_free;
    assign s1_free   = !r_v1 || s12;
    assign acc       = i_smp.valid && s1_free;

    assign i_smp.ready = s1_free;

    // ---------------- stage 1: locate neighbours ----------------
    logic [24:0]    pos_x, pos_y;
    logic [SW-1:0]  lx, ly, hx, hy;
    logic [CW-1:0]  fx, fy;

    always_comb begin
        pos_x = 25'(i_smp.u_coord) * 25'(r_img_w);
        pos_y = 25'(i_smp.v_coord) * 25'(r_img_h);
        lx    = pos_x[24:16];
        ly    = pos_y[24:16];
        fx    = pos_x[15:0];
        fy    = pos_y[15:0];
        // ceiling neighbour, held at the last column or row
        hx    = ((fx != '0) && (lx != r_img_w - SW'(1))) ? lx + SW'(1) : lx;
        hy    = ((fy != '0) && (ly != r_img_h - SW'(1))) ? ly + SW'(1) : ly;
    end

    logic          r1_wen;
    logic [AW-1:0] r1_waddr;
    logic [TW-1:0] r1_rgb;
    logic [SW-1:0] r1_xl, r1_xh, r1_yl, r1_yh;
    logic [CW-1:0] r1_tx, r1_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (acc) begin
            r_v1 <= 1'b1;
        end else if (s12) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_cmd   <= bts_pkg::t_cmd'(i_smp.cmd);
            r1_wen   <= (32'(i_smp.texel_index) < 32'(DEPTH));
            r1_waddr <= AW'(i_smp.texel_index);
            r1_rgb   <= {i_smp.texel_red, i_smp.texel_green, i_smp.texel_blue};
            r1_xl    <= lx;
            r1_xh    <= hx;
            r1_yl    <= ly;
            r1_yh    <= hy;
            r1_tx    <= fx;
            r1_ty    <= fy;
        end
    end

    // ---------------- stage 2: row bases and fetch sequencer ----------------
    logic                       r2_wen;
    logic [AW-1:0]              r2_waddr;
    logic [TW-1:0]              r2_rgb;
    logic [bts_pkg::LIN_W-1:0]  r2_row_lo, r2_row_hi;
    logic [SW-1:0]              r2_xl, r2_xh;
    logic [CW-1:0]              r2_tx, r2_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (s12) begin
                r_v2 <= 1'b1;
            end else if (s2_done) begin
                r_v2 <= 1'b0;
            end
            if (s2_done) begin
                r_cnt <= 2'd0;
            end else if (s2_go) begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s12) begin
            r2_cmd    <= r1_cmd;
            r2_wen    <= r1_wen;
            r2_waddr  <= r1_waddr;
            r2_rgb    <= r1_rgb;
            r2_row_lo <= bts_pkg::LIN_W'(r1_yl) * bts_pkg::LIN_W'(r_img_w);
            r2_row_hi <= bts_pkg::LIN_W'(r1_yh) * bts_pkg::LIN_W'(r_img_w);
            r2_xl     <= r1_xl;
            r2_xh     <= r1_xh;
            r2_tx     <= r1_tx;
            r2_ty     <= r1_ty;
        end
    end

    // fetch order: upper-left, upper-right, lower-left, lower-right
    logic                      mem_we, mem_re, last_rd;
    logic [bts_pkg::LIN_W-1:0] lin;
    logic [AW-1:0]             mem_addr;

    always_comb begin
        lin      = (r_cnt[1] ? r2_row_hi : r2_row_lo) +
                   bts_pkg::LIN_W'(r_cnt[0] ? r2_xh : r2_xl);
        mem_we   = s2_go && is_write && r2_wen;
        mem_re   = s2_go && !is_write;
        last_rd  = mem_re && (r_cnt == 2'd3);
        mem_addr = is_write ? r2_waddr : AW'(lin);
    end

    // ---------------- texel memory ----------------
    logic [TW-1:0] texel_mem [DEPTH];
    logic [TW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            texel_mem[mem_addr] <= r2_rgb;
        end
        if (mem_re) begin
            r_rd_data <= texel_mem[mem_addr];
        end
    end

    // ---------------- gather the first three neighbours ----------------
    logic          r_rd_v;
    logic [1:0]    r_rd_k;
    logic [TW-1:0] r_tex [3];
    logic [CW-1:0] r_p_tx, r_p_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_pv   <= 1'b0;
        end else begin
            r_rd_v <= mem_re && (r_cnt != 2'd3);
            if (last_rd) begin
                r_pv <= 1'b1;
            end else if (s4_take) begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_k <= r_cnt;
        if (r_rd_v) begin
            r_tex[r_rd_k] <= r_rd_data;
        end
        if (last_rd) begin
            r_p_tx <= r2_tx;
            r_p_ty <= r2_ty;
        end
    end

    // ---------------- horizontal blend ----------------
    // the last neighbour is still in the read data register while pending
    logic [23:0]   r_h_top [3];
    logic [23:0]   r_h_bot [3];
    logic [CW-1:0] r_h_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (s4_take) begin
            r_hv <= 1'b1;
        end else if (s5_go) begin
            r_hv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_take) begin
            for (int c = 0; c < 3; c++) begin
                r_h_top[c] <= bts_pkg::lerp_h(bts_pkg::chan(r_tex[0], 2'(c)),
                                              bts_pkg::chan(r_tex[1], 2'(c)), r_p_tx);
                r_h_bot[c] <= bts_pkg::lerp_h(bts_pkg::chan(r_tex[2], 2'(c)),
                                              bts_pkg::chan(r_rd_data, 2'(c)), r_p_tx);
            end
            r_h_ty <= r_p_ty;
        end
    end

    // ---------------- vertical blend into the output register ----------------
    logic [bts_pkg::RESULT_W-1:0] r_out [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s5_go) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s5_go) begin
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= bts_pkg::lerp_v(r_h_top[c], r_h_bot[c], r_h_ty);
            end
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.sample_red   = r_out[0];
    assign o_res.sample_green = r_out[1];
    assign o_res.sample_blue  = r_out[2];

endmodule

`default_nettype wire

/* rtl/core/bts_checker.sv */
// port-level checks for the bilinear texture sampler, bound to the top level.
// depends on bts_pkg for the result width.
`default_nettype none

module bts_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_valid,
    input wire                            i_ready,
    input wire [bts_pkg::RESULT_W-1:0]    i_red,
    input wire [bts_pkg::RESULT_W-1:0]    i_green,
    input wire [bts_pkg::RESULT_W-1:0]    i_blue
);

    // a reset leaves no result on offer
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // a blend of 8-bit channels never exceeds 255.0 in Q8.8
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_red <= 16'hFF00) && (i_green <= 16'hFF00) && (i_blue <= 16'hFF00)))
        else $error("sample channel above 255.0");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("result withdrawn before transfer");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> ($stable(i_red) && $stable(i_green) && $stable(i_blue)))
        else $error("stalled result changed");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_red   (o_res.sample_red),
    .i_green (o_res.sample_green),
    .i_blue  (o_res.sample_blue)
);

`default_nettype wire

/* verif/bilinear_texture_sampler_tb.sv */
`timescale 1ns / 100ps
// testbench for bilinear_texture_sampler: texel writes and bilinear samples are
// checked against a bit-exact blend computed here. depends on bts_pkg, the channel
// interfaces in bts_if and the top level of the block.

module bilinear_texture_sampler_tb;

    localparam int TEXEL_DEPTH  = bts_pkg::MAX_WIDTH_DEF * bts_pkg::MAX_HEIGHT_DEF;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [bts_pkg::RESULT_W-1:0] red;
        logic [bts_pkg::RESULT_W-1:0] green;
        logic [bts_pkg::RESULT_W-1:0] blue;
    } t_rgb_q88;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bts_item_if   smp_bus ();
    bts_result_if res_bus ();
    bts_cfg_if    cfg_bus ();

    bilinear_texture_sampler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    always #2 i_clk = ~i_clk;

    // mirror of the texel memory and the size registers
    logic [bts_pkg::TEXEL_W-1:0] texel_mem [TEXEL_DEPTH];
    bit                          texel_written [TEXEL_DEPTH];
    logic [bts_pkg::SIZE_W-1:0]  width_reg  = bts_pkg::SIZE_W'(bts_pkg::SIZE_RST);
    logic [bts_pkg::SIZE_W-1:0]  height_reg = bts_pkg::SIZE_W'(bts_pkg::SIZE_RST);

    t_rgb_q88 pending_samples[$];
    int       error_count = 0;
    bit       steady_flow = 1'b0;
    int       hold_cycles = 0;

    task automatic report_mismatch(string what, logic [bts_pkg::RESULT_W-1:0] got,
                                   logic [bts_pkg::RESULT_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        error_count++;
    endtask

    function automatic int unsigned usable_size(logic [bts_pkg::SIZE_W-1:0] raw,
                                                int unsigned limit);
        if (raw == 0) return 1;
        if (raw > limit) return limit;
        return 32'(raw);
    endfunction

    // scaled coordinate -> floor and ceiling texel plus Q0.16 weight
    function automatic void split_coord(input logic [bts_pkg::COORD_W-1:0] coord,
                                        input int unsigned size,
                                        output int unsigned lo, output int unsigned hi,
                                        output logic [bts_pkg::COORD_W-1:0] frac);
        logic [31:0] pos;
        pos  = 32'(coord) * 32'(size);
        lo   = 32'(pos[31:16]);
        frac = pos[15:0];
        hi   = lo + ((frac != 0) ? 1 : 0);
        if (lo > size - 1) lo = size - 1;
        if (hi > size - 1) hi = size - 1;
    endfunction

    function automatic t_rgb_q88 blend_sample(logic [bts_pkg::COORD_W-1:0] u,
                                              logic [bts_pkg::COORD_W-1:0] v);
        int unsigned                  w, h, xl, xh, yl, yh, sh;
        logic [bts_pkg::COORD_W-1:0]  tx, ty;
        logic [bts_pkg::TEXEL_W-1:0]  ul, ur, ll, lr;
        logic [63:0]                  w_ul, w_ur, w_ll, w_lr, sum;
        logic [bts_pkg::RESULT_W-1:0] chans [3];
        t_rgb_q88                     res;
        w = usable_size(width_reg, bts_pkg::MAX_WIDTH_DEF);
        h = usable_size(height_reg, bts_pkg::MAX_HEIGHT_DEF);
        split_coord(u, w, xl, xh, tx);
        split_coord(v, h, yl, yh, ty);
        ul = texel_mem[w * yl + xl];
        ur = texel_mem[w * yl + xh];
        ll = texel_mem[w * yh + xl];
        lr = texel_mem[w * yh + xh];
        w_ul = (64'd65536 - 64'(tx)) * (64'd65536 - 64'(ty));
        w_ur = 64'(tx) * (64'd65536 - 64'(ty));
        w_ll = (64'd65536 - 64'(tx)) * 64'(ty);
        w_lr = 64'(tx) * 64'(ty);
        for (int ch = 0; ch < 3; ch++) begin
            sh  = 16 - 8 * ch;
            sum = 64'(ul[sh +: bts_pkg::CHAN_W]) * w_ul + 64'(ur[sh +: bts_pkg::CHAN_W]) * w_ur +
                  64'(ll[sh +: bts_pkg::CHAN_W]) * w_ll + 64'(lr[sh +: bts_pkg::CHAN_W]) * w_lr;
            chans[ch] = sum[39:24];
        end
        res.red   = chans[0];
        res.green = chans[1];
        res.blue  = chans[2];
        return res;
    endfunction

    // one item transfer; valid stays high, with random gaps unless steady_flow is set
    task automatic send_item(bts_pkg::t_cmd cmd, logic [bts_pkg::INDEX_W-1:0] idx,
                             logic [bts_pkg::TEXEL_W-1:0] rgb,
                             logic [bts_pkg::COORD_W-1:0] u, logic [bts_pkg::COORD_W-1:0] v);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < 15) begin
            smp_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        smp_bus.cmd         = cmd;
        smp_bus.texel_index = idx;
        smp_bus.texel_red   = rgb[23:16];
        smp_bus.texel_green = rgb[15:8];
        smp_bus.texel_blue  = rgb[7:0];
        smp_bus.u_coord     = u;
        smp_bus.v_coord     = v;
        smp_bus.valid       = 1'b1;
        do @(posedge i_clk); while (!smp_bus.ready);
        if (cmd == bts_pkg::CMD_WRITE) begin
            texel_mem[idx]     = rgb;
            texel_written[idx] = 1'b1;
        end else begin
            pending_samples.push_back(blend_sample(u, v));
        end
    endtask

    task automatic write_texel(logic [bts_pkg::INDEX_W-1:0] idx,
                               logic [bts_pkg::TEXEL_W-1:0] rgb);
        send_item(bts_pkg::CMD_WRITE, idx, rgb, 16'($urandom), 16'($urandom));
    endtask

    // fills any of the four neighbours not yet written, then requests the sample
    task automatic sample_at(logic [bts_pkg::COORD_W-1:0] u, logic [bts_pkg::COORD_W-1:0] v);
        int unsigned                 w, h, xl, xh, yl, yh;
        logic [bts_pkg::COORD_W-1:0] tx, ty;
        int unsigned                 corner [4];
        w = usable_size(width_reg, bts_pkg::MAX_WIDTH_DEF);
        h = usable_size(height_reg, bts_pkg::MAX_HEIGHT_DEF);
        split_coord(u, w, xl, xh, tx);
        split_coord(v, h, yl, yh, ty);
        corner = '{w * yl + xl, w * yl + xh, w * yh + xl, w * yh + xh};
        foreach (corner[k])
            if (!texel_written[corner[k]]) write_texel(16'(corner[k]), 24'($urandom));
        send_item(bts_pkg::CMD_SAMPLE, 16'($urandom), 24'($urandom), u, v);
    endtask

    // sender pause: nothing offered until every sample is back and writes have settled
    task automatic wait_idle();
        @(negedge i_clk);
        smp_bus.valid = 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(bts_pkg::t_cfg_reg sel, logic [bts_pkg::SIZE_W-1:0] value);
        @(negedge i_clk);
        smp_bus.valid = 1'b0;
        cfg_bus.index = sel;
        cfg_bus.data  = value;
        cfg_bus.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (sel == bts_pkg::CFG_WIDTH) width_reg = value;
        else height_reg = value;
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic set_image_size(logic [bts_pkg::SIZE_W-1:0] w,
                                  logic [bts_pkg::SIZE_W-1:0] h);
        wait_idle();
        write_size(bts_pkg::CFG_WIDTH, w);
        write_size(bts_pkg::CFG_HEIGHT, h);
    endtask

    // mix of edge coordinates, coarse ones with the low byte zero and plain random
    function automatic logic [bts_pkg::COORD_W-1:0] pick_coord();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 30) return 16'($urandom) & 16'hFF00;
        return 16'($urandom);
    endfunction

    task automatic random_items(int count);
        int unsigned r, area;
        area = usable_size(width_reg, bts_pkg::MAX_WIDTH_DEF) *
               usable_size(height_reg, bts_pkg::MAX_HEIGHT_DEF);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 20) write_texel(16'($urandom_range(area - 1)), 24'($urandom));
            else if (r < 25) write_texel(16'($urandom), 24'($urandom));
            else sample_at(pick_coord(), pick_coord());
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_size();
        sample_at('0, '0);
        sample_at('1, '1);
        sample_at(16'h8123, 16'h40F7);
    endtask

    task automatic test_small_grid();
        set_image_size(9'd4, 9'd4);
        for (int i = 0; i < 16; i++) begin
            if (i == 0) write_texel(16'(i), 24'h000000);
            else if (i == 15) write_texel(16'(i), 24'hFFFFFF);
            else write_texel(16'(i), 24'($urandom));
        end
        sample_at('0, '0);
        sample_at('1, '1);
        sample_at(16'h8000, 16'h8000);
        sample_at(16'h4000, 16'hC000);
        sample_at('1, '0);
    endtask

    task automatic test_size_limits();
        // zero size acts as one texel
        set_image_size(9'd0, 9'd0);
        write_texel(16'd0, 24'hFF00FF);
        sample_at('0, '0);
        sample_at('1, '1);
        // sizes above the maximum act as the maximum
        set_image_size(9'd511, 9'd300);
        write_texel(16'hFFFF, 24'hFFFFFF);
        sample_at('1, '1);
        sample_at(16'hFF80, 16'h0000);
        set_image_size(9'd1, 9'd256);
        sample_at(16'h1234, 16'hFFFF);
    endtask

    task automatic test_backpressure();
        set_image_size(9'd8, 9'd8);
        for (int i = 0; i < 64; i++) write_texel(16'(i), 24'($urandom));
        wait_idle();
        steady_flow = 1'b1;
        hold_cycles = 300;
        for (int i = 0; i < 40; i++) sample_at(pick_coord(), pick_coord());
        steady_flow = 1'b0;
        wait_idle();
        hold_cycles = 150;
        for (int i = 0; i < 30; i++) sample_at(pick_coord(), pick_coord());
    endtask

    task automatic test_random();
        logic [bts_pkg::SIZE_W-1:0] w, h;
        for (int p = 0; p < 8; p++) begin
            if (p == 2) begin
                w = 9'($urandom_range(257, 511));
                h = 9'd256;
            end else if (p == 5) begin
                w = 9'd256;
                h = 9'($urandom_range(0, 3));
            end else begin
                w = 9'($urandom_range(0, 16));
                h = 9'($urandom_range(1, 16));
            end
            set_image_size(w, h);
            steady_flow = (p == 4);
            random_items(20);
        end
        steady_flow = 1'b0;
    endtask

    // ---------------------------------------------------------------- result side

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            res_bus.ready = 1'b0;
            hold_cycles--;
        end else if (steady_flow) begin
            res_bus.ready = 1'b1;
        end else begin
            res_bus.ready = ($urandom_range(99) >= 15);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_rgb_q88 want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("unexpected result transfer", res_bus.sample_red, '0);
            end else begin
                want = pending_samples.pop_front();
                if (res_bus.sample_red !== want.red)
                    report_mismatch("sample_red", res_bus.sample_red, want.red);
                if (res_bus.sample_green !== want.green)
                    report_mismatch("sample_green", res_bus.sample_green, want.green);
                if (res_bus.sample_blue !== want.blue)
                    report_mismatch("sample_blue", res_bus.sample_blue, want.blue);
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        smp_bus.valid       = 1'b0;
        smp_bus.cmd         = bts_pkg::CMD_WRITE;
        smp_bus.texel_index = '0;
        smp_bus.texel_red   = '0;
        smp_bus.texel_green = '0;
        smp_bus.texel_blue  = '0;
        smp_bus.u_coord     = '0;
        smp_bus.v_coord     = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = bts_pkg::CFG_WIDTH;
        cfg_bus.data        = '0;
        res_bus.ready       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_size();
        test_small_grid();
        test_size_limits();
        test_backpressure();
        test_random();
        wait_idle();

        if (error_count == 0) begin
            $display("** bilinear_texture_sampler: PASSED **");
        end else begin
            $display("** bilinear_texture_sampler: FAILED **");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("** bilinear_texture_sampler: FAILED **");
        $finish;
    end

endmodule
